/* hw/rtl/servo_command_safety_limiter_defines.svh */
// Assertion helpers for the servo command safety limiter.
// Each use expects clk and arst_n in scope.
`ifndef SERVO_COMMAND_SAFETY_LIMITER_DEFINES_SVH
`define SERVO_COMMAND_SAFETY_LIMITER_DEFINES_SVH

// Same-cycle implication
`define SCLIM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define SCLIM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/sclim_pkg.sv */
package sclim_pkg;

	localparam int ANG_W   = 17;
	localparam int ANGX_W  = 18;
	localparam int SPD_W   = 16;
	localparam int CNT_W   = 32;
	localparam int CFG_W   = 17;
	localparam int CFG_AW  = 3;
	localparam int DT_W    = 16;
	localparam int DTC_W   = 8;
	localparam int PROD_W  = 24;
	localparam int MBV_W   = 15;
	localparam int RECIP_W = 21;
	localparam int RECIP_SHIFT = 30;

	// floor(2^30 / 1000); quotient comes out exact or one short
	localparam logic [RECIP_W-1:0] RECIP   = 21'd1073741;
	localparam logic [9:0]         DIVISOR = 10'd1000;

	localparam logic [DTC_W-1:0] DT_MIN = 8'd1;
	localparam logic [DTC_W-1:0] DT_MAX = 8'd200;

	localparam logic signed [ANG_W-1:0] ABSURD_LIMIT = 17'sd36000;

	typedef enum logic [1:0] {
		CMD_FILTER    = 2'd0,
		CMD_ESTOP_SET = 2'd1,
		CMD_ESTOP_CLR = 2'd2,
		CMD_NONE      = 2'd3
	} cmd_e;

	typedef enum logic [CFG_AW-1:0] {
		REG_YAW_LO   = 3'd0,
		REG_YAW_HI   = 3'd1,
		REG_PITCH_LO = 3'd2,
		REG_PITCH_HI = 3'd3,
		REG_SPEED_LO = 3'd4,
		REG_SPEED_HI = 3'd5,
		REG_VELOCITY = 3'd6,
		REG_STEP     = 3'd7
	} reg_idx_e;

	typedef enum logic [2:0] {
		V_OK     = 3'd0,
		V_ABSURD = 3'd1,
		V_TRAVEL = 3'd2,
		V_STEP   = 3'd3,
		V_VEL    = 3'd4,
		V_WDOG   = 3'd5,
		V_ESTOP  = 3'd6
	} verdict_e;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} pipe_en_t;

	typedef struct packed {
		logic signed [ANG_W-1:0] pos;
		logic signed [ANG_W-1:0] cur;
		logic                    travel;
		logic                    limited;
	} lane_res_t;

	typedef struct packed {
		logic             hold;
		verdict_e         hold_verdict;
		logic [SPD_W-1:0] speed;
		logic             speed_mod;
	} ctl_t;

	// with reversed limits, a value below low gives low and any other gives high
	function automatic logic signed [ANGX_W-1:0] clamp18(
		input logic signed [ANGX_W-1:0] v,
		input logic signed [ANGX_W-1:0] lo,
		input logic signed [ANGX_W-1:0] hi
	);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

endpackage

/* hw/rtl/sclim_budget.sv */
// Per-step travel budget: min(velocity * dt / 1000, step limit).
module sclim_budget (
	input  logic                              clk,
	input  sclim_pkg::pipe_en_t               en,
	input  logic [sclim_pkg::SPD_W-1:0]       velocity_limit,
	input  logic [sclim_pkg::SPD_W-1:0]       step_limit,
	input  logic [sclim_pkg::DT_W-1:0]        step_time_ms,
	output logic [sclim_pkg::SPD_W-1:0]       budget,
	output logic                              vel_sel
);
	import sclim_pkg::*;

	localparam int WIDE_W = PROD_W + RECIP_W;

	logic [DTC_W-1:0]  dtc;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] prod_s1;
	logic [WIDE_W-1:0] wide;
	logic [MBV_W-1:0]  q0_s2;
	logic [PROD_W-1:0] prod_s2;
	logic [PROD_W-1:0] back;
	logic [PROD_W-1:0] rem;
	logic [SPD_W-1:0]  mbv;
	logic [SPD_W-1:0]  budget_s3;
	logic              vel_s3;

	always_comb begin
		if (step_time_ms == '0) begin
			dtc = DT_MIN;
		end else if (step_time_ms > DT_W'(DT_MAX)) begin
			dtc = DT_MAX;
		end else begin
			dtc = step_time_ms[DTC_W-1:0];
		end
		prod = PROD_W'(velocity_limit) * PROD_W'(dtc);
	end

	assign wide = WIDE_W'(prod_s1) * WIDE_W'(RECIP);

	// reciprocal quotient is at most one short; one compare fixes it
	always_comb begin
		back = PROD_W'(q0_s2) * PROD_W'(DIVISOR);
		rem  = prod_s2 - back;
		mbv  = SPD_W'(q0_s2) + SPD_W'(rem >= PROD_W'(DIVISOR));
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			prod_s1 <= prod;
		end
		if (en.s2) begin
			q0_s2   <= wide[RECIP_SHIFT +: MBV_W];
			prod_s2 <= prod_s1;
		end
		if (en.s3) begin
			budget_s3 <= (mbv < step_limit) ? mbv : step_limit;
			vel_s3    <= (mbv <= step_limit);
		end
	end

	assign budget  = budget_s3;
	assign vel_sel = vel_s3;

endmodule

/* hw/rtl/sclim_lane.sv */
// One axis: travel clamp, slew limit against the budget, final clamps.
module sclim_lane #(
	parameter int HARD_MIN = -9000,
	parameter int HARD_MAX = 9000
) (
	input  logic                                clk,
	input  sclim_pkg::pipe_en_t                 en,
	input  logic signed [sclim_pkg::ANG_W-1:0]  req,
	input  logic signed [sclim_pkg::ANG_W-1:0]  cur,
	input  logic signed [sclim_pkg::ANG_W-1:0]  lo,
	input  logic signed [sclim_pkg::ANG_W-1:0]  hi,
	input  logic [sclim_pkg::SPD_W-1:0]         budget,
	output sclim_pkg::lane_res_t                res
);
	import sclim_pkg::*;

	localparam logic signed [ANGX_W-1:0] HARD_LO = ANGX_W'(HARD_MIN);
	localparam logic signed [ANGX_W-1:0] HARD_HI = ANGX_W'(HARD_MAX);

	logic signed [ANGX_W-1:0] lo_x;
	logic signed [ANGX_W-1:0] hi_x;
	logic signed [ANGX_W-1:0] yc_x;
	logic signed [ANG_W-1:0]  yc_s1, yc_s2, yc_s3;
	logic signed [ANG_W-1:0]  cur_s1, cur_s2, cur_s3;
	logic                     trav_s1, trav_s2, trav_s3;

	logic signed [ANGX_W-1:0] d;
	logic        [ANGX_W-1:0] ad;
	logic signed [ANGX_W-1:0] stp;
	logic signed [ANGX_W-1:0] p;
	logic signed [ANGX_W-1:0] p_trav;
	logic signed [ANGX_W-1:0] p_hard;
	logic                     lim;
	lane_res_t                res_s4;

	assign lo_x = ANGX_W'(lo);
	assign hi_x = ANGX_W'(hi);
	assign yc_x = clamp18(ANGX_W'(req), lo_x, hi_x);

	always_comb begin
		d   = ANGX_W'(yc_s3) - ANGX_W'(cur_s3);
		ad  = (d < 0) ? ANGX_W'(-d) : ANGX_W'(d);
		lim = ad > ANGX_W'(budget);
		stp = $signed({2'b00, budget});
		if (!lim) begin
			p = ANGX_W'(yc_s3);
		end else if (d > 0) begin
			p = ANGX_W'(cur_s3) + stp;
		end else begin
			p = ANGX_W'(cur_s3) - stp;
		end
		p_trav = clamp18(p, lo_x, hi_x);
		p_hard = clamp18(p_trav, HARD_LO, HARD_HI);
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			yc_s1   <= yc_x[ANG_W-1:0];
			cur_s1  <= cur;
			trav_s1 <= (yc_x[ANG_W-1:0] != req);
		end
		if (en.s2) begin
			yc_s2   <= yc_s1;
			cur_s2  <= cur_s1;
			trav_s2 <= trav_s1;
		end
		if (en.s3) begin
			yc_s3   <= yc_s2;
			cur_s3  <= cur_s2;
			trav_s3 <= trav_s2;
		end
		if (en.s4) begin
			res_s4.pos     <= p_hard[ANG_W-1:0];
			res_s4.cur     <= cur_s3;
			res_s4.travel  <= trav_s3;
			res_s4.limited <= lim;
		end
	end

	assign res = res_s4;

endmodule

/* hw/rtl/sclim_merge.sv */
// Combines both lanes: verdict, modified flag, counters, output register.
module sclim_merge (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               load,
	input  sclim_pkg::ctl_t                    ctl,
	input  sclim_pkg::lane_res_t               yaw,
	input  sclim_pkg::lane_res_t               pitch,
	input  logic                               vel_sel,
	output logic signed [sclim_pkg::ANG_W-1:0] out_yaw,
	output logic signed [sclim_pkg::ANG_W-1:0] out_pitch,
	output logic [sclim_pkg::SPD_W-1:0]        out_speed,
	output sclim_pkg::verdict_e                verdict,
	output logic                               modified,
	output logic [sclim_pkg::CNT_W-1:0]        rejected_count,
	output logic [sclim_pkg::CNT_W-1:0]        clamped_count
);
	import sclim_pkg::*;

	logic signed [ANG_W-1:0] yaw_n, pitch_n;
	verdict_e                verdict_n;
	logic                    mod_n;
	logic [1:0]              clamp_inc;
	logic                    rej_inc;
	logic                    lim_any;
	logic                    trav_any;

	logic signed [ANG_W-1:0] yaw_s5, pitch_s5;
	logic [SPD_W-1:0]        speed_s5;
	verdict_e                verdict_s5;
	logic                    mod_s5;
	logic [CNT_W-1:0]        rej_q, clamp_q;

	always_comb begin
		lim_any  = yaw.limited | pitch.limited;
		trav_any = yaw.travel | pitch.travel;
		if (ctl.hold) begin
			yaw_n     = yaw.cur;
			pitch_n   = pitch.cur;
			verdict_n = ctl.hold_verdict;
			mod_n     = 1'b1;
			rej_inc   = (ctl.hold_verdict == V_ABSURD);
			clamp_inc = 2'd0;
		end else begin
			yaw_n   = yaw.pos;
			pitch_n = pitch.pos;
			if (lim_any) begin
				verdict_n = vel_sel ? V_VEL : V_STEP;
			end else if (trav_any) begin
				verdict_n = V_TRAVEL;
			end else begin
				verdict_n = V_OK;
			end
			mod_n     = (verdict_n != V_OK) | ctl.speed_mod;
			rej_inc   = 1'b0;
			clamp_inc = 2'(trav_any) + 2'(yaw.limited) + 2'(pitch.limited);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rej_q   <= '0;
			clamp_q <= '0;
		end else if (load) begin
			rej_q   <= rej_q + CNT_W'(rej_inc);
			clamp_q <= clamp_q + CNT_W'(clamp_inc);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			yaw_s5     <= yaw_n;
			pitch_s5   <= pitch_n;
			speed_s5   <= ctl.speed;
			verdict_s5 <= verdict_n;
			mod_s5     <= mod_n;
		end
	end

	assign out_yaw        = yaw_s5;
	assign out_pitch      = pitch_s5;
	assign out_speed      = speed_s5;
	assign verdict        = verdict_s5;
	assign modified       = mod_s5;
	assign rejected_count = rej_q;
	assign clamped_count  = clamp_q;

endmodule

/* hw/rtl/servo_command_safety_limiter.sv */
// Servo command safety limiter: slew-rate limiter with travel clamps.
// Input stream s_*: one request per beat. s_tuser carries the command
// (filter, set e-stop, clear e-stop) and the valid flag of the request;
// s_tdata carries requested and current pose and the step time.
// Only filter requests produce a result; e-stop commands change the latch
// at acceptance and vanish, so later requests see them in order.
// Output stream m_*: safe pose, speed and both counters in m_tdata,
// verdict and modified flag in m_tuser.
// Throughput: one request per cycle unless m_tready stalls; the path is five
// register stages, the first loaded at acceptance (multiply, reciprocal
// multiply, quotient fix-up, per-axis lanes, merge/output register).
// A stalled m_tready holds the output register; earlier stages keep filling
// into empty slots, so s_tready only drops once every stage is occupied.
// Reset: e-stop cleared, counters zero, limit registers to their defaults,
// pipeline empty. Config writes (cfg_we/cfg_addr/cfg_wdata) take effect at
// once and must only happen with the pipeline drained.
module servo_command_safety_limiter #(
	parameter int HARD_MIN_YAW   = -9000,
	parameter int HARD_MAX_YAW   = 9000,
	parameter int HARD_MIN_PITCH = -4500,
	parameter int HARD_MAX_PITCH = 4500
) (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            cfg_we,
	input  logic [sclim_pkg::CFG_AW-1:0]    cfg_addr,
	input  logic [sclim_pkg::CFG_W-1:0]     cfg_wdata,

	input  logic                            s_tvalid,
	output logic                            s_tready,
	// req_yaw, req_pitch, req_speed, cur_yaw, cur_pitch, cur_speed,
	// step_time_ms, zero pad
	input  logic [119:0]                    s_tdata,
	// command, req_valid
	input  logic [2:0]                      s_tuser,

	output logic                            m_tvalid,
	input  logic                            m_tready,
	// out_yaw, out_pitch, out_speed, rejected_count, clamped_count, zero pad
	output logic [119:0]                    m_tdata,
	// verdict, modified
	output logic [3:0]                      m_tuser
);
	import sclim_pkg::*;

	// limit registers
	logic signed [ANG_W-1:0] yaw_lo_q, yaw_hi_q, pitch_lo_q, pitch_hi_q;
	logic [SPD_W-1:0]        speed_lo_q, speed_hi_q, vel_q, step_q;
	logic                    estop_q;

	// request fields
	cmd_e                    command;
	logic                    req_valid;
	logic signed [ANG_W-1:0] req_yaw, req_pitch, req_speed, cur_yaw, cur_pitch;
	logic [DT_W-1:0]         step_time_ms;

	// pipeline control
	logic     v1, v2, v3, v4, v5;
	pipe_en_t en;
	logic     accept;

	// side band carried alongside the lanes
	ctl_t                     ctl_in, ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic                     vel_s4;
	logic signed [ANGX_W-1:0] spd_x;
	logic                     absurd;

	logic [SPD_W-1:0] budget;
	logic             vel_sel;
	lane_res_t        yaw_res, pitch_res;

	logic signed [ANG_W-1:0] out_yaw, out_pitch;
	logic [SPD_W-1:0]        out_speed;
	verdict_e                verdict;
	logic                    modified;
	logic [CNT_W-1:0]        rejected_count, clamped_count;

	assign command      = cmd_e'(s_tuser[1:0]);
	assign req_valid    = s_tuser[2];
	assign req_yaw      = s_tdata[16:0];
	assign req_pitch    = s_tdata[33:17];
	assign req_speed    = s_tdata[50:34];
	assign cur_yaw      = s_tdata[67:51];
	assign cur_pitch    = s_tdata[84:68];
	assign step_time_ms = s_tdata[117:102];

	// Configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_lo_q   <= -17'sd3000;
			yaw_hi_q   <= 17'sd3000;
			pitch_lo_q <= -17'sd1000;
			pitch_hi_q <= 17'sd1000;
			speed_lo_q <= 16'd1000;
			speed_hi_q <= 16'd30000;
			vel_q      <= 16'd18000;
			step_q     <= 16'd1500;
		end else if (cfg_we) begin
			unique case (reg_idx_e'(cfg_addr))
				REG_YAW_LO:   yaw_lo_q   <= cfg_wdata;
				REG_YAW_HI:   yaw_hi_q   <= cfg_wdata;
				REG_PITCH_LO: pitch_lo_q <= cfg_wdata;
				REG_PITCH_HI: pitch_hi_q <= cfg_wdata;
				REG_SPEED_LO: speed_lo_q <= cfg_wdata[SPD_W-1:0];
				REG_SPEED_HI: speed_hi_q <= cfg_wdata[SPD_W-1:0];
				REG_VELOCITY: vel_q      <= cfg_wdata[SPD_W-1:0];
				REG_STEP:     step_q     <= cfg_wdata[SPD_W-1:0];
				default:      ;
			endcase
		end
	end

	// Stall chain: a stage moves when it is empty or its successor moves.
	always_comb begin
		en.s5 = !v5 || m_tready;
		en.s4 = !v4 || en.s5;
		en.s3 = !v3 || en.s4;
		en.s2 = !v2 || en.s3;
		en.s1 = !v1 || en.s2;
	end

	assign s_tready = en.s1;
	assign accept   = s_tvalid && s_tready;

	// E-stop latch, updated in request order at acceptance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			estop_q <= 1'b0;
		end else if (accept) begin
			case (command)
				CMD_ESTOP_SET: estop_q <= 1'b1;
				CMD_ESTOP_CLR: estop_q <= 1'b0;
				default:       ;
			endcase
		end
	end

	// Hold decision and speed clamp (held requests leave at the least speed)
	always_comb begin
		absurd = (req_yaw > ABSURD_LIMIT) || (req_yaw < -ABSURD_LIMIT) ||
			(req_pitch > ABSURD_LIMIT) || (req_pitch < -ABSURD_LIMIT);
		spd_x  = clamp18(ANGX_W'(req_speed), $signed({2'b00, speed_lo_q}),
			$signed({2'b00, speed_hi_q}));
		ctl_in.hold = estop_q || !req_valid || absurd;
		if (estop_q) begin
			ctl_in.hold_verdict = V_ESTOP;
		end else if (!req_valid) begin
			ctl_in.hold_verdict = V_WDOG;
		end else begin
			ctl_in.hold_verdict = V_ABSURD;
		end
		ctl_in.speed     = ctl_in.hold ? speed_lo_q : spd_x[SPD_W-1:0];
		ctl_in.speed_mod = (spd_x != ANGX_W'(req_speed));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1 <= 1'b0;
			v2 <= 1'b0;
			v3 <= 1'b0;
			v4 <= 1'b0;
			v5 <= 1'b0;
		end else begin
			if (en.s1) v1 <= accept && (command == CMD_FILTER);
			if (en.s2) v2 <= v1;
			if (en.s3) v3 <= v2;
			if (en.s4) v4 <= v3;
			if (en.s5) v5 <= v4;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) ctl_s1 <= ctl_in;
		if (en.s2) ctl_s2 <= ctl_s1;
		if (en.s3) ctl_s3 <= ctl_s2;
		if (en.s4) begin
			ctl_s4 <= ctl_s3;
			vel_s4 <= vel_sel;
		end
	end

	sclim_budget u_budget (
		.clk            (clk),
		.en             (en),
		.velocity_limit (vel_q),
		.step_limit     (step_q),
		.step_time_ms   (step_time_ms),
		.budget         (budget),
		.vel_sel        (vel_sel)
	);

	sclim_lane #(
		.HARD_MIN (HARD_MIN_YAW),
		.HARD_MAX (HARD_MAX_YAW)
	) u_lane_yaw (
		.clk    (clk),
		.en     (en),
		.req    (req_yaw),
		.cur    (cur_yaw),
		.lo     (yaw_lo_q),
		.hi     (yaw_hi_q),
		.budget (budget),
		.res    (yaw_res)
	);

	sclim_lane #(
		.HARD_MIN (HARD_MIN_PITCH),
		.HARD_MAX (HARD_MAX_PITCH)
	) u_lane_pitch (
		.clk    (clk),
		.en     (en),
		.req    (req_pitch),
		.cur    (cur_pitch),
		.lo     (pitch_lo_q),
		.hi     (pitch_hi_q),
		.budget (budget),
		.res    (pitch_res)
	);

	sclim_merge u_merge (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (en.s5 && v4),
		.ctl            (ctl_s4),
		.yaw            (yaw_res),
		.pitch          (pitch_res),
		.vel_sel        (vel_s4),
		.out_yaw        (out_yaw),
		.out_pitch      (out_pitch),
		.out_speed      (out_speed),
		.verdict        (verdict),
		.modified       (modified),
		.rejected_count (rejected_count),
		.clamped_count  (clamped_count)
	);

	assign m_tvalid = v5;
	assign m_tdata  = {6'b0, clamped_count, rejected_count, out_speed, out_pitch, out_yaw};
	assign m_tuser  = {modified, verdict};

	// Checks
	`include "servo_command_safety_limiter_defines.svh"

	localparam logic signed [ANG_W-1:0] YAW_MIN_C   = ANG_W'(HARD_MIN_YAW);
	localparam logic signed [ANG_W-1:0] YAW_MAX_C   = ANG_W'(HARD_MAX_YAW);
	localparam logic signed [ANG_W-1:0] PITCH_MIN_C = ANG_W'(HARD_MIN_PITCH);
	localparam logic signed [ANG_W-1:0] PITCH_MAX_C = ANG_W'(HARD_MAX_PITCH);

	`SCLIM_ASSERT_NOW(a_hold_modified,
		m_tvalid && (verdict == V_ESTOP || verdict == V_WDOG || verdict == V_ABSURD),
		modified, "held result without modified flag")

	`SCLIM_ASSERT_NOW(a_hard_bounds,
		m_tvalid && verdict != V_ESTOP && verdict != V_WDOG && verdict != V_ABSURD,
		out_yaw >= YAW_MIN_C && out_yaw <= YAW_MAX_C &&
		out_pitch >= PITCH_MIN_C && out_pitch <= PITCH_MAX_C,
		"filtered pose outside hardware bounds")

	`SCLIM_ASSERT_NEXT(a_reject_count,
		en.s5 && v4 && ctl_s4.hold && ctl_s4.hold_verdict == V_ABSURD,
		rejected_count == $past(rejected_count) + 32'd1,
		"reject counter missed an absurd request")

endmodule
